// File: src/rpt_stride_prefetcher_assert.svh
// ----------------------------------------------------------------------------
// Stride prefetcher assertion macros
// Shared concurrent assertion forms for the stride prefetcher blocks.
// ----------------------------------------------------------------------------
`ifndef RPT_STRIDE_PREFETCHER_ASSERT_SVH
`define RPT_STRIDE_PREFETCHER_ASSERT_SVH

// same-cycle implication
`define RPT_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rpt: same-cycle check failed");

// next-cycle implication
`define RPT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rpt: next-cycle check failed");

`endif

// File: src/rpt_pkg.sv
// ----------------------------------------------------------------------------
// Stride prefetcher package
// Shared types and constants of the reference prediction table prefetcher.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int ADDR_W    = 32;
    localparam int STEP_W    = 13;
    localparam int BURST_W   = 5;
    localparam int LEFT_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_STEP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH = 1'd1;

    localparam logic [STEP_W-1:0]  BLOCK_STEP_RESET   = 13'd64;
    localparam logic [BURST_W-1:0] BURST_LENGTH_RESET = 5'd4;
    localparam logic [BURST_W-1:0] BURST_MAX          = 5'd16;

    typedef logic [1:0] rpt_kind_t;

    localparam rpt_kind_t KIND_MISS = 2'd0;
    localparam rpt_kind_t KIND_HIT  = 2'd1;
    localparam rpt_kind_t KIND_DONE = 2'd2;

    typedef struct packed {
        rpt_kind_t           kind;
        logic [ADDR_W-1:0]   pc;
        logic [ADDR_W-1:0]   addr;
    } rpt_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] prev_addr;
    } rpt_row_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } rpt_back_ctl_t;

endpackage

// File: src/rpt_stride_prefetcher.sv
// ----------------------------------------------------------------------------
// Reference prediction table stride prefetcher
// Front end classifies requests and finds the row, a two-entry queue feeds
// the back end, which owns the table, the burst state and the result register.
//
//   port group   direction  handshake          payload
//   s_*          in         s_valid / s_ready  command, access_pc, access_addr, hit_l1
//   m_*          out        m_valid / m_ready  prefetch_valid, prefetch_addr
//   cfg_*        in         cfg_we             cfg_index, cfg_wdata
//
// Back end per request: a table read, then compute and write-back, held by a stalled output.
// Front end forms the row index from a reciprocal estimate, then a corrected remainder.
// After reset the table is cleared one row a cycle, all TABLE_ROWS rows, s_ready low.
// A stalled result holds in the output register; the queue keeps the front moving.
// ----------------------------------------------------------------------------
module rpt_stride_prefetcher #(
    parameter int TABLE_ROWS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpt_pkg::STEP_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [rpt_pkg::ADDR_W-1:0]     s_access_pc,
    input  logic [rpt_pkg::ADDR_W-1:0]     s_access_addr,
    input  logic                           s_hit_l1,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_prefetch_valid,
    output logic [rpt_pkg::ADDR_W-1:0]     m_prefetch_addr
);
    import rpt_pkg::*;

    localparam int IW = $clog2(TABLE_ROWS);

    rpt_back_ctl_t  ctl;
    logic           q_valid;
    rpt_req_t       q_entry;
    logic [IW-1:0]  q_row;

    rpt_front #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_access_pc   (s_access_pc),
        .s_access_addr (s_access_addr),
        .s_hit_l1      (s_hit_l1),
        .ctl           (ctl),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_row         (q_row)
    );

    rpt_back #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_row            (q_row),
        .ctl              (ctl),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prefetch_valid (m_prefetch_valid),
        .m_prefetch_addr  (m_prefetch_addr)
    );

endmodule

// File: src/rpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rpt_front.sv
// ----------------------------------------------------------------------------
// Stride prefetcher front end
// Accepts requests, classifies them, computes the table row and queues them.
// ----------------------------------------------------------------------------
`include "rpt_stride_prefetcher_assert.svh"

module rpt_front #(
    parameter int TABLE_ROWS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [rpt_pkg::ADDR_W-1:0]     s_access_pc,
    input  logic [rpt_pkg::ADDR_W-1:0]     s_access_addr,
    input  logic                           s_hit_l1,
    input  rpt_pkg::rpt_back_ctl_t         ctl,
    output logic                           q_valid,
    output rpt_pkg::rpt_req_t              q_entry,
    output logic [$clog2(TABLE_ROWS)-1:0]  q_row
);
    import rpt_pkg::*;

    localparam int          IW     = $clog2(TABLE_ROWS);
    localparam logic [63:0] RECIP  = (64'd1 << 32) / TABLE_ROWS;
    localparam logic [31:0] ROWS32 = 32'(TABLE_ROWS);

    logic              stage_vld_reg;
    logic              stage_phase_reg;
    rpt_req_t          stage_reg;
    logic [31:0]       q_est_reg;
    logic [63:0]       prod;
    logic [31:0]       rem_raw;
    logic [31:0]       rem_fix;
    logic              accept;
    logic              push;
    rpt_kind_t         kind;

    rpt_req_t          qe_reg   [2];
    logic [IW-1:0]     qrow_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    always_comb begin
        if (s_command) begin
            kind = KIND_DONE;
        end else if (s_hit_l1) begin
            kind = KIND_HIT;
        end else begin
            kind = KIND_MISS;
        end
    end

    assign prod    = {32'd0, stage_reg.pc} * {32'd0, RECIP[31:0]};
    assign rem_raw = stage_reg.pc - 32'(q_est_reg * ROWS32);
    assign rem_fix = (rem_raw >= ROWS32) ? rem_raw - ROWS32 : rem_raw;

    assign push    = stage_vld_reg && stage_phase_reg && (count_reg != 2'd2);
    assign s_ready = !ctl.clearing && (!stage_vld_reg || push);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg   <= 1'b0;
            stage_phase_reg <= 1'b0;
        end else if (accept) begin
            stage_vld_reg   <= 1'b1;
            stage_phase_reg <= 1'b0;
        end else if (push) begin
            stage_vld_reg   <= 1'b0;
            stage_phase_reg <= 1'b0;
        end else if (stage_vld_reg) begin
            stage_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg.kind <= kind;
            stage_reg.pc   <= s_access_pc;
            stage_reg.addr <= s_access_addr;
        end
        if (stage_vld_reg && !stage_phase_reg) begin
            q_est_reg <= prod[63:32];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !ctl.pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && ctl.pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (ctl.pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            qe_reg[wr_ptr_reg]   <= stage_reg;
            qrow_reg[wr_ptr_reg] <= rem_fix[IW-1:0];
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_entry = qe_reg[rd_ptr_reg];
    assign q_row   = qrow_reg[rd_ptr_reg];

    `RPT_ASSERT_IMP(a_queue_bound, aclk, aresetn, 1'b1, count_reg != 2'd3)
    `RPT_ASSERT_IMP(a_phase_needs_stage, aclk, aresetn, stage_phase_reg, stage_vld_reg)

endmodule

// File: src/rpt_back.sv
// ----------------------------------------------------------------------------
// Stride prefetcher back end
// Clears the table, looks up rows, updates strides and the burst state.
// ----------------------------------------------------------------------------
`include "rpt_stride_prefetcher_assert.svh"

module rpt_back #(
    parameter int TABLE_ROWS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpt_pkg::STEP_W-1:0]     cfg_wdata,
    input  logic                           q_valid,
    input  rpt_pkg::rpt_req_t              q_entry,
    input  logic [$clog2(TABLE_ROWS)-1:0]  q_row,
    output rpt_pkg::rpt_back_ctl_t         ctl,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_prefetch_valid,
    output logic [rpt_pkg::ADDR_W-1:0]     m_prefetch_addr
);
    import rpt_pkg::*;

    localparam int            IW       = $clog2(TABLE_ROWS);
    localparam int            RW       = $bits(rpt_row_t);
    localparam logic [IW-1:0] LAST_ROW = IW'(TABLE_ROWS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]         state_reg;
    logic [IW-1:0]      clr_cnt_reg;
    rpt_req_t           cur_reg;
    logic [IW-1:0]      cur_row_reg;
    logic               pending_reg;
    logic [ADDR_W-1:0]  next_addr_reg;
    logic [ADDR_W-1:0]  next_pc_reg;
    logic [IW-1:0]      next_row_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic [STEP_W-1:0]  blk_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               m_valid_reg;
    logic               m_pvalid_reg;
    logic [ADDR_W-1:0]  m_paddr_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    rpt_row_t           ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;

    rpt_row_t           row;
    logic               go;
    logic               tag_hit;
    logic [ADDR_W-1:0]  step_blk;
    logic [ADDR_W-1:0]  miss_s;
    logic [LEFT_W-1:0]  burst_left;
    logic               start;
    logic [ADDR_W-1:0]  target;
    logic               wr_row;
    logic [ADDR_W-1:0]  wr_stride;
    logic               pending_next;
    logic [ADDR_W-1:0]  next_addr_next;
    logic [LEFT_W-1:0]  left_next;

    rpt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign row      = rpt_row_t'(ram_rdata);
    assign go       = (state_reg == ST_LOOK) && (!m_valid_reg || m_ready);
    assign step_blk = ADDR_W'(blk_reg);
    assign miss_s   = cur_reg.addr - row.prev_addr;

    assign ctl.pop      = (state_reg == ST_IDLE) && q_valid;
    assign ctl.clearing = (state_reg == ST_CLEAR);

    assign ram_re    = ctl.pop;
    assign ram_raddr = (q_entry.kind == KIND_DONE) ? next_row_reg : q_row;

    always_comb begin
        if (burst_reg == '0) begin
            burst_left = '0;
        end else if (burst_reg > BURST_MAX) begin
            burst_left = LEFT_W'(BURST_MAX - 5'd1);
        end else begin
            burst_left = LEFT_W'(burst_reg - 5'd1);
        end
    end

    always_comb begin
        tag_hit        = 1'b0;
        start          = 1'b0;
        target         = cur_reg.addr + step_blk;
        wr_row         = 1'b0;
        wr_stride      = '0;
        pending_next   = pending_reg;
        next_addr_next = next_addr_reg;
        left_next      = left_reg;
        case (cur_reg.kind)
            KIND_DONE: begin
                tag_hit = (row.tag == next_pc_reg);
                if (left_reg == '0) begin
                    pending_next = 1'b0;
                end else begin
                    left_next      = left_reg - 4'd1;
                    next_addr_next = next_addr_reg + (tag_hit ? row.stride : step_blk);
                end
            end
            KIND_HIT: begin
                tag_hit = (row.tag == cur_reg.pc);
                if (!pending_reg) begin
                    start = 1'b1;
                    if (tag_hit) begin
                        target = cur_reg.addr + row.stride;
                    end
                end
            end
            KIND_MISS: begin
                tag_hit = (row.tag == cur_reg.pc);
                start   = 1'b1;
                wr_row  = 1'b1;
                if (tag_hit) begin
                    if (miss_s == row.stride) begin
                        wr_stride = row.stride;
                        target    = cur_reg.addr + row.stride;
                    end else begin
                        wr_stride = miss_s;
                    end
                end
            end
            default: begin
                pending_next = pending_reg;
            end
        endcase
        if (start) begin
            pending_next   = 1'b1;
            next_addr_next = target;
            left_next      = burst_left;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_row_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end else if (go && wr_row) begin
            ram_we              = 1'b1;
            ram_wdata.tag       = cur_reg.pc;
            ram_wdata.stride    = wr_stride;
            ram_wdata.prev_addr = cur_reg.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == LAST_ROW) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.pop) begin
            cur_reg     <= q_entry;
            cur_row_reg <= q_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg   <= BLOCK_STEP_RESET;
            burst_reg <= BURST_LENGTH_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_BLOCK_STEP) begin
                blk_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_BURST_LENGTH) begin
                burst_reg <= cfg_wdata[BURST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            next_addr_reg <= '0;
            next_pc_reg   <= '0;
            next_row_reg  <= '0;
            left_reg      <= '0;
        end else if (go) begin
            pending_reg   <= pending_next;
            next_addr_reg <= next_addr_next;
            left_reg      <= left_next;
            if (start) begin
                next_pc_reg  <= cur_reg.pc;
                next_row_reg <= cur_row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_pvalid_reg <= pending_next;
            m_paddr_reg  <= pending_next ? next_addr_next : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_prefetch_valid = m_pvalid_reg;
    assign m_prefetch_addr  = m_paddr_reg;

    `RPT_ASSERT_IMP(a_idle_left_zero, aclk, aresetn, !pending_reg, left_reg == '0)
    `RPT_ASSERT_NEXT(a_result_loaded, aclk, aresetn, go, m_valid_reg)
    `RPT_ASSERT_IMP(a_no_pop_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !ctl.pop && !ram_re)
    `RPT_ASSERT_IMP(a_idle_addr_zero, aclk, aresetn, m_valid_reg && !m_pvalid_reg, m_paddr_reg == '0)

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stride prefetcher testbench
// Drives CPU access and completion requests into the prefetcher, keeps its own
// model of the prediction table and the burst state, and checks every result
// in order. A directed table covers the corner cases at reset configuration;
// random phases then walk several block step and burst length settings under
// different sender and receiver idle rates.
// ----------------------------------------------------------------------------
module tb;
    import rpt_pkg::*;

    localparam int TBL_ROWS = 256;
    localparam int TBL_IW = $clog2(TBL_ROWS);
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_DONE   = 1'b1;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
    } prefetch_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        bit                typed;
        prefetch_t         res;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0000_0000}},
        '{CMD_ACCESS, 32'h0000_0000, 32'h0000_1000, 1'b1, 1'b1, '{1'b1, 32'h0000_1000}},
        '{CMD_ACCESS, 32'h0000_0005, 32'h1234_5678, 1'b1, 1'b1, '{1'b1, 32'h0000_1000}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h0000_1000}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h0000_1000}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h0000_1000}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0000_0000}},
        '{CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0, 1'b1, '{1'b1, 32'h0000_0030}},
        '{CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0010, 1'b0, 1'b1, '{1'b1, 32'h0000_0050}},
        '{CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0030, 1'b0, 1'b1, '{1'b1, 32'h0000_0050}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h0000_0070}},
        '{CMD_ACCESS, 32'h0000_01FF, 32'h8000_0000, 1'b0, 1'b1, '{1'b1, 32'h8000_0040}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h8000_0040}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h8000_0040}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h8000_0040}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0000_0000}},
        '{CMD_ACCESS, 32'h0000_03FF, 32'hFFFF_FFC0, 1'b1, 1'b1, '{1'b1, 32'h0000_0000}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'h0000_0040}},
        '{CMD_ACCESS, 32'h0000_03FF, 32'h0000_1000, 1'b0, 1'b1, '{1'b1, 32'h0000_1040}},
        '{CMD_ACCESS, 32'h0000_03FF, 32'h0000_0FF0, 1'b0, 1'b1, '{1'b1, 32'h0000_1030}},
        '{CMD_ACCESS, 32'h0000_03FF, 32'h0000_0FE0, 1'b0, 1'b1, '{1'b1, 32'h0000_0FD0}},
        '{CMD_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0000_0000}},
        '{CMD_DONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '{1'b0, 32'h0000_0000}},
        '{CMD_ACCESS, 32'h0000_03FF, 32'hAAAA_5555, 1'b1, 1'b0, '{1'b0, 32'h0000_0000}},
        '{CMD_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '{1'b0, 32'h0000_0000}}
    };

    localparam logic [STEP_W-1:0] PH_STEP  [RAND_PHASES] = '{
        13'd1, 13'd4096, 13'd0, 13'h1FFF, 13'd64
    };
    localparam logic [STEP_W-1:0] PH_BURST [RAND_PHASES] = '{
        13'd1, 13'd16, 13'd0, 13'h1FFF, 13'd17
    };
    localparam int PH_SEND_IDLE [RAND_PHASES] = '{0, 63, 0, 18, 0};
    localparam int PH_RECV_STALL [RAND_PHASES] = '{0, 0, 63, 18, 0};

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_STEP;
    logic [STEP_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_ACCESS;
    logic [ADDR_W-1:0]    s_access_pc = '0;
    logic [ADDR_W-1:0]    s_access_addr = '0;
    logic                 s_hit_l1 = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_prefetch_valid;
    logic [ADDR_W-1:0]    m_prefetch_addr;

    logic [ADDR_W-1:0]  tbl_tag    [TBL_ROWS] = '{default: '0};
    logic [ADDR_W-1:0]  tbl_stride [TBL_ROWS] = '{default: '0};
    logic [ADDR_W-1:0]  tbl_last   [TBL_ROWS] = '{default: '0};
    logic               pf_pending = 1'b0;
    logic [ADDR_W-1:0]  pf_addr = '0;
    logic [ADDR_W-1:0]  pf_pc = '0;
    logic [LEFT_W-1:0]  pf_left = '0;
    logic [STEP_W-1:0]  cfg_step = BLOCK_STEP_RESET;
    logic [BURST_W-1:0] cfg_burst = BURST_LENGTH_RESET;

    prefetch_t prefetch_q [$];
    int        err_cnt = 0;
    int        send_idle_pct = 0;
    int        ready_stall_pct = 0;

    logic [ADDR_W-1:0] strm_pc     [8];
    logic [ADDR_W-1:0] strm_addr   [8];
    logic [ADDR_W-1:0] strm_stride [8];

    always #5 aclk = ~aclk;

    rpt_stride_prefetcher #(
        .TABLE_ROWS(TBL_ROWS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_access_pc      (s_access_pc),
        .s_access_addr    (s_access_addr),
        .s_hit_l1         (s_hit_l1),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prefetch_valid (m_prefetch_valid),
        .m_prefetch_addr  (m_prefetch_addr)
    );

    function automatic logic [ADDR_W-1:0] step_word();
        return {{(ADDR_W-STEP_W){1'b0}}, cfg_step};
    endfunction

    function automatic void begin_burst(input logic [ADDR_W-1:0] pc,
                                        input logic [ADDR_W-1:0] target);
        logic [BURST_W-1:0] n;
        n = cfg_burst;
        if (n == '0) n = BURST_W'(1);
        if (n > BURST_MAX) n = BURST_MAX;
        pf_left = LEFT_W'(n - 1);
        pf_pending = 1'b1;
        pf_addr = target;
        pf_pc = pc;
    endfunction

    function automatic prefetch_t next_prefetch(input logic cmd,
                                                input logic [ADDR_W-1:0] pc,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic hit);
        logic [TBL_IW-1:0] r;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] target;
        prefetch_t         res;
        if (cmd == CMD_DONE) begin
            if (pf_left == '0) begin
                pf_pending = 1'b0;
            end else begin
                r = TBL_IW'(pf_pc % TBL_ROWS);
                pf_left = pf_left - 1'b1;
                pf_addr = pf_addr + ((tbl_tag[r] == pf_pc) ? tbl_stride[r] : step_word());
            end
        end else if (hit) begin
            if (!pf_pending) begin
                r = TBL_IW'(pc % TBL_ROWS);
                begin_burst(pc, addr + ((tbl_tag[r] == pc) ? tbl_stride[r] : step_word()));
            end
        end else begin
            r = TBL_IW'(pc % TBL_ROWS);
            if (tbl_tag[r] == pc) begin
                s = addr - tbl_last[r];
                if (s == tbl_stride[r]) begin
                    target = addr + s;
                end else begin
                    tbl_stride[r] = s;
                    target = addr + step_word();
                end
            end else begin
                tbl_stride[r] = '0;
                target = addr + step_word();
            end
            tbl_tag[r] = pc;
            tbl_last[r] = addr;
            begin_burst(pc, target);
        end
        res.vld = pf_pending;
        res.addr = pf_pending ? pf_addr : '0;
        return res;
    endfunction

    task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] pc,
                                input logic [ADDR_W-1:0] addr, input logic hit,
                                input bit typed, input prefetch_t typed_res);
        prefetch_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_access_pc <= pc;
        s_access_addr <= addr;
        s_hit_l1 <= hit;
        do @(posedge aclk); while (!s_ready);
        res = next_prefetch(cmd, pc, addr, hit);
        if (typed) res = typed_res;
        prefetch_q.push_back(res);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (prefetch_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_config(input logic [STEP_W-1:0] step,
                                input logic [STEP_W-1:0] burst);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BLOCK_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        cfg_index <= CFG_BURST_LENGTH;
        cfg_wdata <= burst;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_step = step;
        cfg_burst = burst[BURST_W-1:0];
    endtask

    // check results in order
    always @(posedge aclk) begin
        prefetch_t want;
        m_ready <= ($urandom_range(99) >= ready_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (prefetch_q.size() == 0) begin
                $error("unexpected result: prefetch_valid %0d prefetch_addr %h",
                       m_prefetch_valid, m_prefetch_addr);
                err_cnt++;
            end else begin
                want = prefetch_q.pop_front();
                if (m_prefetch_valid !== want.vld) begin
                    $error("prefetch_valid: expected %0d, got %0d", want.vld,
                           m_prefetch_valid);
                    err_cnt++;
                end
                if (m_prefetch_addr !== want.addr) begin
                    $error("prefetch_addr: expected %h, got %h", want.addr,
                           m_prefetch_addr);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic              cmd;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        int                k;
        logic [2:0]        sel;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] burst;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tbl[i])
            send_request(dir_tbl[i].cmd, dir_tbl[i].pc, dir_tbl[i].addr, dir_tbl[i].hit,
                         dir_tbl[i].typed, dir_tbl[i].res);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            step = PH_STEP[p];
            burst = PH_BURST[p];
            if (p == RAND_PHASES - 1) begin
                step = STEP_W'($urandom_range(1, 4096));
                burst = STEP_W'($urandom_range(2, 15));
            end
            write_config(step, burst);
            send_idle_pct = PH_SEND_IDLE[p];
            ready_stall_pct = PH_RECV_STALL[p];
            for (int j = 0; j < 8; j++) begin
                strm_pc[j] = $urandom;
                strm_addr[j] = $urandom;
                case ($urandom_range(3))
                    0: strm_stride[j] = ADDR_W'($urandom_range(16)) << 2;
                    1: strm_stride[j] = -(ADDR_W'($urandom_range(1, 16)) << 6);
                    2: strm_stride[j] = $urandom;
                    default: strm_stride[j] = '0;
                endcase
            end
            strm_pc[0] = '0;
            strm_pc[1] = {24'($urandom), strm_pc[2][7:0]};

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) drain();
                k = $urandom_range(99);
                sel = 3'($urandom_range(7));
                pc = $urandom;
                addr = $urandom;
                hit = 1'($urandom_range(1));
                cmd = CMD_ACCESS;
                if (k < 35) begin
                    cmd = CMD_DONE;
                end else if (k < 75) begin
                    if ($urandom_range(19) == 0) strm_stride[sel] = $urandom;
                    strm_addr[sel] = strm_addr[sel] + strm_stride[sel];
                    pc = strm_pc[sel];
                    addr = strm_addr[sel];
                    hit = 1'b0;
                end else if (k < 90) begin
                    pc = strm_pc[sel];
                    addr = strm_addr[sel] + ADDR_W'($urandom_range(255));
                    hit = 1'b1;
                end else if (k < 95) begin
                    pc = {24'($urandom), strm_pc[sel][7:0]};
                end
                send_request(cmd, pc, addr, hit, 1'b0, '0);
            end
            drain();
        end

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: rpt_stride_prefetcher.f
+incdir+src
src/rpt_pkg.sv
src/rpt_ram.sv
src/rpt_front.sv
src/rpt_back.sv
src/rpt_stride_prefetcher.sv
tb/tb.sv
